// ----- rtl/core/lrds_pkg.sv -----
// ----------------------------------------------------------------------------
// lrds_pkg
// shared types and constants for the random draw and shuffle block
// ----------------------------------------------------------------------------
package lrds_pkg;

    localparam int MAX_PERM   = 64;
    localparam int IDX_W      = $clog2(MAX_PERM);
    localparam int CNT_W      = IDX_W + 1;
    localparam int QUEUE_D    = 2;

    localparam logic [30:0] MODULUS   = 31'h7FFF_FFFF;
    localparam logic [25:0] MULT      = 26'd62089911;
    localparam logic [28:0] INCR      = 29'd453816693;
    localparam logic [30:0] SEED_RST  = 31'd1;
    localparam logic [30:0] THR_RST   = 31'd1073741824;

    localparam logic [0:0] ADDR_SEED = 1'b0;
    localparam logic [0:0] ADDR_THR  = 1'b1;

    typedef enum logic [0:0] {
        CMD_DRAW = 1'b0,
        CMD_PERM = 1'b1
    } t_cmd;

    // classified job handed from front to back
    typedef struct packed {
        t_cmd              cmd;
        logic signed [31:0] lo;
        logic [32:0]       span;
        logic              err;
        logic [CNT_W-1:0]  n;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_RED,
        S_SPAN,
        S_DIV,
        S_DRAW_OUT,
        S_FILL,
        S_SW_RD,
        S_SW_WR,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    // x mod (2^31-1) for x below 2^62, one fold and a final correction
    function automatic logic [30:0] mod_m(input logic [61:0] x);
        logic [31:0] s;
        logic [31:0] t;
        begin
            s = {1'b0, x[30:0]} + {1'b0, x[61:31]};
            t = {1'b0, s[30:0]} + {31'd0, s[31]};
            if (t[30:0] == MODULUS || t[31]) t = t - {1'b0, MODULUS};
            mod_m = t[30:0];
        end
    endfunction

endpackage

// ----- rtl/core/lrds_if.sv -----
// ----------------------------------------------------------------------------
// lrds_in_if / lrds_out_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface lrds_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [6:0]         perm_count;
    modport source (output valid, command, range_low, range_high, perm_count, input ready);
    modport sink   (input valid, command, range_low, range_high, perm_count, output ready);
endinterface

interface lrds_out_if;
    logic               valid;
    logic               ready;
    logic [30:0]        raw_value;
    logic signed [31:0] range_value;
    logic               bernoulli_flag;
    logic               range_error;
    logic [5:0]         perm_element;
    logic               last;
    modport source (output valid, raw_value, range_value, bernoulli_flag, range_error,
                    perm_element, last, input ready);
    modport sink   (input valid, raw_value, range_value, bernoulli_flag, range_error,
                    perm_element, last, output ready);
endinterface

// ----- rtl/core/lcg_range_draw_and_shuffle.sv -----
// ----------------------------------------------------------------------------
// lcg_range_draw_and_shuffle
// random draws, bernoulli flag and permutations from a 31-bit generator
// ----------------------------------------------------------------------------
// Requests enter on s_in (valid/ready); command 0 is a single draw, command 1
// a permutation of perm_count elements, clamped to 1..64. Results leave on
// m_out with last set on the final result of each request. A front stage
// classifies requests into a two-entry job queue; the back end runs the
// generator. A draw goes from job start to result register through multiply,
// reduce, range multiply, divide fix-up and output. A permutation of n fills
// the store, does n-1 swaps and emits n elements, each read then output,
// all through the single-write port of the 64-entry store.
// Reset loads seed 1 and threshold 2^30 and empties the queue.
// When the receiver stalls the output register holds and the back end waits;
// the front keeps taking requests until the queue is full.
// Registers: seed at 0x0 (write also loads the generator), threshold at 0x4.
// ----------------------------------------------------------------------------
module lcg_range_draw_and_shuffle (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lrds_in_if.sink     s_in,
    lrds_out_if.source  m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [30:0]    r_seed, r_thr;
    logic           w_wr, w_seed_we;
    logic           w_job_valid, w_job_pop;
    lrds_pkg::t_job w_job;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_seed_we = w_wr && (paddr[2] == lrds_pkg::ADDR_SEED) && (paddr[1:0] == 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= lrds_pkg::SEED_RST;
            r_thr  <= lrds_pkg::THR_RST;
        end else if (w_wr && paddr[1:0] == 2'd0) begin
            if (paddr[2] == lrds_pkg::ADDR_SEED) r_seed <= pwdata[30:0];
            else r_thr <= pwdata[30:0];
        end
    end

    always_comb begin
        case (paddr[2])
            lrds_pkg::ADDR_SEED: prdata = {1'b0, r_seed};
            lrds_pkg::ADDR_THR:  prdata = {1'b0, r_thr};
            default:             prdata = 32'd0;
        endcase
    end

    lrds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_in        (s_in),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    lrds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .i_seed_we   (w_seed_we),
        .i_seed      (pwdata[30:0]),
        .i_thr       (r_thr),
        .m_out       (m_out)
    );
endmodule

// ----- rtl/core/lrds_ram.sv -----
// ----------------------------------------------------------------------------
// lrds_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module lrds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/core/lrds_front.sv -----
// ----------------------------------------------------------------------------
// lrds_front
// accepts requests, classifies them and queues jobs for the back end
// ----------------------------------------------------------------------------
module lrds_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lrds_in_if.sink             s_in,
    output logic                o_job_valid,
    output lrds_pkg::t_job      o_job,
    input  logic                i_job_pop
);
    lrds_pkg::t_job r_q [lrds_pkg::QUEUE_D];
    logic [1:0]     r_cnt;
    logic           r_wp;
    logic           r_rp;
    lrds_pkg::t_job w_job;
    logic           w_push;
    logic signed [32:0] w_diff;
    logic [6:0]     w_n;

    assign s_in.ready  = (r_cnt != 2'(lrds_pkg::QUEUE_D));
    assign w_push      = s_in.valid && s_in.ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_comb begin
        w_diff = {s_in.range_high[31], s_in.range_high} - {s_in.range_low[31], s_in.range_low};
        w_n    = s_in.perm_count;
        if (w_n == 7'd0) w_n = 7'd1;
        if (w_n > 7'(lrds_pkg::MAX_PERM)) w_n = 7'(lrds_pkg::MAX_PERM);
        w_job.cmd  = lrds_pkg::t_cmd'(s_in.command);
        w_job.lo   = s_in.range_low;
        w_job.err  = w_diff[32];
        w_job.span = w_diff[32:0] + 33'd1;
        w_job.n    = w_n[lrds_pkg::CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_job_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_job_pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_pop |-> o_job_valid) else $error("pop from empty job queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(lrds_pkg::QUEUE_D)) else $error("job queue overflow");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_job_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count lost a push");
endmodule

// ----- rtl/core/lrds_back.sv -----
// ----------------------------------------------------------------------------
// lrds_back
// generator, range scaling and shuffle sequencer
// ----------------------------------------------------------------------------
module lrds_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  lrds_pkg::t_job      i_job,
    output logic                o_job_pop,
    input  logic                i_seed_we,
    input  logic [30:0]         i_seed,
    input  logic [30:0]         i_thr,
    lrds_out_if.source          m_out
);
    localparam int IW = lrds_pkg::IDX_W;
    localparam int CW = lrds_pkg::CNT_W;

    lrds_pkg::t_state r_st, n_st;
    lrds_pkg::t_job   r_job;
    logic [30:0]      r_gen;
    logic [56:0]      r_prod;
    logic [63:0]      r_sprod;
    logic [31:0]      r_q;
    logic [CW-1:0]    r_i;
    logic [IW-1:0]    r_j;
    logic [5:0]       r_ei, r_ej;
    logic [30:0]      r_raw;
    logic [30:0]      r_oraw;
    logic signed [31:0] r_val;
    logic             r_flag, r_err;
    logic [5:0]       r_elem;
    logic             r_last;
    logic             r_ovalid;

    logic             w_we;
    logic [IW-1:0]    w_waddr, w_raddr;
    logic [5:0]       w_wdata, w_rdata;
    logic             w_out_free;
    logic [32:0]      w_fold;
    logic [30:0]      w_new;
    logic [31:0]      w_q;
    logic [CW-1:0]    w_ip1;
    logic [IW-1:0]    w_jc;

    lrds_ram #(.WIDTH(6), .DEPTH(lrds_pkg::MAX_PERM)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_ovalid || m_out.ready;
    assign w_new = lrds_pkg::mod_m({5'd0, r_prod} + 62'(lrds_pkg::INCR));
    assign w_ip1 = r_i + CW'(1);

    // floor(x / (2^31-1)): x = a*2^31 + b = a*m + (a+b), and a+b stays below 3m
    always_comb begin
        w_fold = {1'b0, r_sprod[62:31]} + {2'b0, r_sprod[30:0]};
        w_q    = r_sprod[62:31];
        if (w_fold >= {1'b0, lrds_pkg::MODULUS, 1'b0}) w_q = w_q + 32'd2;
        else if (w_fold >= {2'b0, lrds_pkg::MODULUS}) w_q = w_q + 32'd1;
    end

    always_comb begin
        w_jc = w_q[IW-1:0];
        if (w_q > 32'(r_i)) w_jc = r_i[IW-1:0];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            lrds_pkg::S_IDLE:     if (i_job_valid) n_st = lrds_pkg::S_MUL;
            lrds_pkg::S_MUL:      n_st = lrds_pkg::S_RED;
            lrds_pkg::S_RED:      n_st = lrds_pkg::S_SPAN;
            lrds_pkg::S_SPAN:     n_st = lrds_pkg::S_DIV;
            lrds_pkg::S_DIV:      n_st = (r_job.cmd == lrds_pkg::CMD_DRAW) ?
                                         lrds_pkg::S_DRAW_OUT : lrds_pkg::S_SW_RD;
            lrds_pkg::S_DRAW_OUT: if (w_out_free) n_st = lrds_pkg::S_IDLE;
            lrds_pkg::S_FILL:     if (r_i == r_job.n - CW'(1)) begin
                                      n_st = (r_job.n == CW'(1)) ?
                                             lrds_pkg::S_EMIT_RD : lrds_pkg::S_MUL;
                                  end
            lrds_pkg::S_SW_RD:    n_st = lrds_pkg::S_SW_WR;
            lrds_pkg::S_SW_WR:    n_st = (r_i == CW'(1)) ? lrds_pkg::S_EMIT_RD
                                                         : lrds_pkg::S_MUL;
            lrds_pkg::S_EMIT_RD:  n_st = lrds_pkg::S_EMIT_OUT;
            lrds_pkg::S_EMIT_OUT: if (w_out_free) begin
                                      n_st = (r_i == r_job.n - CW'(1)) ?
                                             lrds_pkg::S_IDLE : lrds_pkg::S_EMIT_RD;
                                  end
            default:              n_st = lrds_pkg::S_IDLE;
        endcase
        if (r_st == lrds_pkg::S_IDLE && i_job_valid && i_job.cmd == lrds_pkg::CMD_PERM)
            n_st = lrds_pkg::S_FILL;
    end

    // ram port control and job pop: fill, swap read/write and emit read
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_i[IW-1:0];
        w_wdata = r_i[5:0];
        w_raddr = r_i[IW-1:0];
        o_job_pop = (r_st == lrds_pkg::S_IDLE) && i_job_valid;
        case (r_st)
            lrds_pkg::S_FILL:   w_we = 1'b1;
            lrds_pkg::S_DIV:    w_raddr = w_jc;
            lrds_pkg::S_SW_RD:  begin
                w_we = 1'b1; w_waddr = r_j; w_wdata = r_ei;
            end
            lrds_pkg::S_SW_WR:  begin
                w_we = 1'b1; w_waddr = r_i[IW-1:0]; w_wdata = r_ej;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= lrds_pkg::S_IDLE;
            r_gen    <= lrds_pkg::SEED_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == lrds_pkg::S_RED) r_gen <= w_new;
            else if (i_seed_we) r_gen <= i_seed;
            if ((r_st == lrds_pkg::S_DRAW_OUT || r_st == lrds_pkg::S_EMIT_OUT) && w_out_free)
                r_ovalid <= 1'b1;
            else if (m_out.ready)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            lrds_pkg::S_IDLE: begin
                r_job <= i_job;
                r_i   <= '0;
            end
            lrds_pkg::S_MUL:  r_prod <= 57'(r_gen) * 57'(lrds_pkg::MULT);
            lrds_pkg::S_RED:  r_raw <= w_new;
            lrds_pkg::S_SPAN: begin
                if (r_job.cmd == lrds_pkg::CMD_DRAW)
                    r_sprod <= 64'(r_job.span) * 64'(r_raw);
                else
                    r_sprod <= 64'(w_ip1) * 64'(r_raw);
            end
            lrds_pkg::S_DIV: begin
                r_q  <= w_q;
                r_j  <= w_jc;
                // element at i, read while in S_SPAN
                r_ei <= w_rdata;
            end
            lrds_pkg::S_FILL: begin
                if (r_i == r_job.n - CW'(1)) begin
                    if (r_job.n != CW'(1)) r_i <= r_i;
                    else r_i <= '0;
                end else r_i <= w_ip1;
            end
            lrds_pkg::S_SW_RD: r_ej <= w_rdata;
            lrds_pkg::S_SW_WR: r_i <= (r_i == CW'(1)) ? '0 : r_i - CW'(1);
            lrds_pkg::S_EMIT_OUT: if (w_out_free) r_i <= w_ip1;
            default: ;
        endcase
        if (r_st == lrds_pkg::S_DRAW_OUT && w_out_free) begin
            r_oraw <= r_raw;
            r_val  <= r_job.err ? r_job.lo : r_job.lo + r_q;
            r_flag <= r_raw < i_thr;
            r_err  <= r_job.err;
            r_elem <= 6'd0;
            r_last <= 1'b1;
        end
        if (r_st == lrds_pkg::S_EMIT_OUT && w_out_free) begin
            r_oraw <= '0;
            r_val  <= '0;
            r_flag <= 1'b0;
            r_err  <= 1'b0;
            r_elem <= w_rdata;
            r_last <= (r_i == r_job.n - CW'(1));
        end
    end

    assign m_out.valid          = r_ovalid;
    assign m_out.raw_value      = r_oraw;
    assign m_out.range_value    = r_val;
    assign m_out.bernoulli_flag = r_flag;
    assign m_out.range_error    = r_err;
    assign m_out.perm_element   = r_elem;
    assign m_out.last           = r_last;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> (r_st == lrds_pkg::S_IDLE)) else $error("pop while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_out.ready) |=> r_ovalid) else $error("result dropped");
    a_gen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == lrds_pkg::S_RED) |=> (r_gen != lrds_pkg::MODULUS))
        else $error("generator left range");
endmodule
